// ===== sv/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned WidthW  = 3;
  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [1:0] {
    END_NONE       = 2'd0,
    END_BAD_LEAD   = 2'd1,
    END_INCOMPLETE = 2'd2,
    END_ZERO       = 2'd3
  } end_kind_e;

  // Sequence widths
  localparam logic [WidthW-1:0] SEQ_NONE = 3'd0;
  localparam logic [WidthW-1:0] SEQ_W1   = 3'd1;
  localparam logic [WidthW-1:0] SEQ_W2   = 3'd2;
  localparam logic [WidthW-1:0] SEQ_W3   = 3'd3;
  localparam logic [WidthW-1:0] SEQ_W4   = 3'd4;

  localparam logic [CpW-1:0] MIN_W2     = 21'h80;
  localparam logic [CpW-1:0] MIN_W3     = 21'h800;
  localparam logic [CpW-1:0] MIN_W4     = 21'h10000;
  localparam logic [CpW-1:0] SURR_LO    = 21'hD800;
  localparam logic [CpW-1:0] SURR_HI    = 21'hDFFF;
  localparam logic [CpW-1:0] UNICODE_MAX = 21'h10FFFF;

  // One finished sequence or end event handed from front to back
  typedef struct packed {
    logic [CpW-1:0]    cp;
    logic [WidthW-1:0] width;
    logic              bad;
    end_kind_e         kind;
    logic              eos;
  } seq_rec_t;

endpackage

// ===== sv/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// RFC 3629 UTF-8 decoder, one byte per beat, one code point per sequence.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid_i/in_ready_o | data_byte_i, last_byte_i
//  out     | out_valid_o/out_ready_i | code_point_o, bad_trailing_o,
//          |                       | overlong_o, not_unicode_o, end_kind_o,
//          |                       | end_of_string_o
//
//  One byte per cycle while the queue has room; the front writes a finished result
//  into the queue, then the grading stage registers it into the output register.
//  The front takes a byte whenever the record queue has a free slot.
//  A stall on out backs up into the queue and then holds in_ready_o low.
//  Reset clears the sequence state, the queue and the output valid.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8sd_pkg::*; #(
  parameter int unsigned QueueDepth = Q_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           bad_trailing_o,
  output logic           overlong_o,
  output logic           not_unicode_o,
  output logic [1:0]     end_kind_o,
  output logic           end_of_string_o
);

  logic     push, q_ready, q_valid, pop;
  seq_rec_t push_rec, head;

  u8sd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .push_o      (push),
    .push_rec_o  (push_rec),
    .q_ready_i   (q_ready)
  );

  u8sd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  u8sd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_point_o    (code_point_o),
    .bad_trailing_o  (bad_trailing_o),
    .overlong_o      (overlong_o),
    .not_unicode_o   (not_unicode_o),
    .end_kind_o      (end_kind_o),
    .end_of_string_o (end_of_string_o)
  );

endmodule

// ===== sv/u8sd_front.sv =====
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts bytes, tracks the open sequence and pushes one record per result.
// ----------------------------------------------------------------------------
module u8sd_front import u8sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       push_o,
  output seq_rec_t   push_rec_o,
  input  logic       q_ready_i
);

  logic [1:0]        rem_q, rem_d;
  logic [WidthW-1:0] width_q, width_d;
  logic [CpW-1:0]    acc_q, acc_d;
  logic              bad_q, bad_d;
  logic              stop_q, stop_d;

  logic              fire;
  logic              emit;
  seq_rec_t          rec;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i & q_ready_i;

  always_comb begin
    logic [CpW-1:0]    v;
    logic [WidthW-1:0] w;
    logic              b;
    logic              done;
    logic [1:0]        rem_n;

    rem_d   = rem_q;
    width_d = width_q;
    acc_d   = acc_q;
    bad_d   = bad_q;
    stop_d  = stop_q;
    emit    = 1'b0;
    rec     = '{cp: '0, width: SEQ_NONE, bad: 1'b0, kind: END_NONE, eos: 1'b1};
    v       = '0;
    w       = SEQ_NONE;
    b       = 1'b0;
    done    = 1'b0;
    rem_n   = 2'd0;

    if (stop_q) begin
      // drop bytes up to the end of the buffer
      if (last_byte_i) stop_d = 1'b0;
    end else if (rem_q == 2'd0) begin
      if (!data_byte_i[7]) begin
        w = SEQ_W1; v = {14'd0, data_byte_i[6:0]}; done = 1'b1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        w = SEQ_W2; v = {16'd0, data_byte_i[4:0]}; rem_n = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        w = SEQ_W3; v = {17'd0, data_byte_i[3:0]}; rem_n = 2'd2;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        w = SEQ_W4; v = {18'd0, data_byte_i[2:0]}; rem_n = 2'd3;
      end else begin
        emit = 1'b1;
        rec.kind = END_BAD_LEAD;
        stop_d = ~last_byte_i;
      end
      if (w != SEQ_NONE && !done) begin
        if (last_byte_i) begin
          emit = 1'b1;
          rec.kind = END_INCOMPLETE;
          rem_d = 2'd0; width_d = SEQ_NONE; acc_d = '0; bad_d = 1'b0;
        end else begin
          rem_d = rem_n; width_d = w; acc_d = v; bad_d = 1'b0;
        end
      end
    end else begin
      w = width_q;
      b = bad_q | (data_byte_i[7:6] != 2'b10);
      v = {acc_q[CpW-7:0], data_byte_i[5:0]};
      rem_n = rem_q - 2'd1;
      if (rem_n == 2'd0) begin
        done = 1'b1;
      end else if (last_byte_i) begin
        emit = 1'b1;
        rec.kind = END_INCOMPLETE;
        rem_d = 2'd0; width_d = SEQ_NONE; acc_d = '0; bad_d = 1'b0;
      end else begin
        rem_d = rem_n; acc_d = v; bad_d = b;
      end
    end

    if (done) begin
      emit = 1'b1;
      rem_d = 2'd0; width_d = SEQ_NONE; acc_d = '0; bad_d = 1'b0;
      rec.cp    = v;
      rec.width = w;
      rec.bad   = b;
      if (v == '0) begin
        rec.kind = END_ZERO;
        rec.eos  = 1'b1;
        stop_d   = ~last_byte_i;
      end else begin
        rec.kind = END_NONE;
        rec.eos  = last_byte_i;
      end
    end
  end

  assign push_o     = fire & emit;
  assign push_rec_o = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= 2'd0;
      width_q <= SEQ_NONE;
      acc_q   <= '0;
      bad_q   <= 1'b0;
      stop_q  <= 1'b0;
    end else if (fire) begin
      rem_q   <= rem_d;
      width_q <= width_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ===== sv/u8sd_queue.sv =====
// ----------------------------------------------------------------------------
// u8sd_queue
// Short ring queue of sequence records between front and back.
// ----------------------------------------------------------------------------
module u8sd_queue import u8sd_pkg::*; #(
  parameter int unsigned QueueDepth = Q_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seq_rec_t push_rec_i,
  output logic     ready_o,
  output logic     valid_o,
  output seq_rec_t head_o,
  input  logic     pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  seq_rec_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/u8sd_back.sv =====
// ----------------------------------------------------------------------------
// u8sd_back
// Grades a finished sequence and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module u8sd_back import u8sd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  seq_rec_t       q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [CpW-1:0] code_point_o,
  output logic           bad_trailing_o,
  output logic           overlong_o,
  output logic           not_unicode_o,
  output logic [1:0]     end_kind_o,
  output logic           end_of_string_o
);

  logic           valid_q;
  logic [CpW-1:0] cp_q;
  logic           bad_q, ovl_q, nu_q, eos_q;
  end_kind_e      kind_q;
  logic           ovl_d, nu_d;
  logic [CpW-1:0] v;

  assign v     = q_head_i.cp;
  assign ovl_d = ((q_head_i.width == SEQ_W2) && (v < MIN_W2)) ||
                 ((q_head_i.width == SEQ_W3) && (v < MIN_W3)) ||
                 ((q_head_i.width == SEQ_W4) && (v < MIN_W4));
  assign nu_d  = ((v >= SURR_LO) && (v <= SURR_HI)) || (v > UNICODE_MAX);

  // advance when the output slot is empty or being drained
  assign pop_o = q_valid_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (~valid_q | out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cp_q   <= v;
      bad_q  <= q_head_i.bad;
      ovl_q  <= ovl_d;
      nu_q   <= nu_d;
      kind_q <= q_head_i.kind;
      eos_q  <= q_head_i.eos;
    end
  end

  assign out_valid_o     = valid_q;
  assign code_point_o    = cp_q;
  assign bad_trailing_o  = bad_q;
  assign overlong_o      = ovl_q;
  assign not_unicode_o   = nu_q;
  assign end_kind_o      = kind_q;
  assign end_of_string_o = eos_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder testbench
// Feeds byte buffers with random bursts and gaps, stalls the result side on
// shifting patterns plus one long hold-off, and checks every code point
// against a cycle-free decoder kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
  import u8sd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned BYTE_TARGET     = 720;

  typedef struct {
    logic [CpW-1:0] cp;
    logic           bad;
    logic           ovl;
    logic           nu;
    end_kind_e      kind;
    logic           eos;
  } decoded_t;

  class cp_checker;
    logic [1:0]        trail_left;
    logic [WidthW-1:0] seq_w;
    logic [CpW-1:0]    acc;
    logic              trail_err;
    logic              halted;
    decoded_t          cp_expected_q[$];
    int unsigned       consumed;
    int unsigned       mismatches;

    function new();
      drop_seq();
      halted     = 1'b0;
      consumed   = 0;
      mismatches = 0;
    endfunction

    function void drop_seq();
      trail_left = 2'd0;
      seq_w      = SEQ_NONE;
      acc        = '0;
      trail_err  = 1'b0;
    endfunction

    function void push_cp(logic [CpW-1:0] cp, logic bad, logic ovl, logic nu,
                          end_kind_e kind, logic eos);
      decoded_t r;
      r.cp   = cp;
      r.bad  = bad;
      r.ovl  = ovl;
      r.nu   = nu;
      r.kind = kind;
      r.eos  = eos;
      cp_expected_q.push_back(r);
    endfunction

    function void close_seq(logic lst);
      logic [CpW-1:0]    v;
      logic [WidthW-1:0] w;
      logic              ovl;
      logic              nu;
      logic              bad;
      v   = acc;
      w   = seq_w;
      bad = trail_err;
      ovl = (w == SEQ_W2 && v < MIN_W2) || (w == SEQ_W3 && v < MIN_W3) ||
            (w == SEQ_W4 && v < MIN_W4);
      nu  = (v >= SURR_LO && v <= SURR_HI) || v > UNICODE_MAX;
      drop_seq();
      if (v == '0) begin
        push_cp('0, bad, ovl, nu, END_ZERO, 1'b1);
        halted = !lst;
      end else begin
        push_cp(v, bad, ovl, nu, END_NONE, lst);
      end
    endfunction

    // Advance the decoder by one accepted byte.
    function void take_byte(logic [7:0] b, logic lst);
      if (halted) begin
        if (lst) halted = 1'b0;
        return;
      end
      consumed++;
      if (trail_left == 2'd0) begin
        trail_err = 1'b0;
        if (!b[7]) begin
          seq_w = SEQ_W1;
          acc   = {14'd0, b[6:0]};
        end else if (b[7:5] == 3'b110) begin
          seq_w = SEQ_W2;
          acc   = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          seq_w = SEQ_W3;
          acc   = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_w = SEQ_W4;
          acc   = {18'd0, b[2:0]};
        end else begin
          drop_seq();
          push_cp('0, 1'b0, 1'b0, 1'b0, END_BAD_LEAD, 1'b1);
          halted = !lst;
          return;
        end
        if (seq_w == SEQ_W1) begin
          close_seq(lst);
        end else if (lst) begin
          drop_seq();
          push_cp('0, 1'b0, 1'b0, 1'b0, END_INCOMPLETE, 1'b1);
        end else begin
          trail_left = 2'(seq_w - 3'd1);
        end
        return;
      end
      if (b[7:6] != 2'b10) trail_err = 1'b1;
      acc        = {acc[14:0], b[5:0]};
      trail_left = trail_left - 2'd1;
      if (trail_left == 2'd0) begin
        close_seq(lst);
      end else if (lst) begin
        drop_seq();
        push_cp('0, 1'b0, 1'b0, 1'b0, END_INCOMPLETE, 1'b1);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_cp(decoded_t got);
      decoded_t exp_cp;
      if (cp_expected_q.size() == 0) begin
        report($sformatf("unexpected result: cp=%h kind=%0d eos=%b",
                         got.cp, got.kind, got.eos));
        return;
      end
      exp_cp = cp_expected_q.pop_front();
      if (got.cp !== exp_cp.cp || got.bad !== exp_cp.bad || got.ovl !== exp_cp.ovl ||
          got.nu !== exp_cp.nu || got.kind !== exp_cp.kind || got.eos !== exp_cp.eos)
        report($sformatf({"mismatch: expected cp=%h bad=%b ovl=%b nu=%b kind=%0d eos=%b,",
                          " got cp=%h bad=%b ovl=%b nu=%b kind=%0d eos=%b"},
                         exp_cp.cp, exp_cp.bad, exp_cp.ovl, exp_cp.nu, exp_cp.kind,
                         exp_cp.eos, got.cp, got.bad, got.ovl, got.nu, got.kind,
                         got.eos));
    endfunction

    function int unsigned pending();
      return cp_expected_q.size();
    endfunction
  endclass

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic [7:0]     data_byte = 8'h00;
  logic           last_byte = 1'b0;
  logic           out_ready = 1'b0;
  logic           in_ready;
  logic           out_valid;
  logic [CpW-1:0] code_point;
  logic           bad_trailing;
  logic           overlong;
  logic           not_unicode;
  logic [1:0]     end_kind;
  logic           end_of_string;

  cp_checker   board = new();
  bit          hold_off_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned cycle_cnt = 0;

  // last flag in bit 8, byte below
  logic [8:0] directed_seq [26] = '{
    9'h141, 9'h100, 9'h0C0, 9'h180, 9'h0E2, 9'h082, 9'h1AC, 9'h0ED, 9'h0A0,
    9'h180, 9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF, 9'h080, 9'h041, 9'h142, 9'h1C3,
    9'h0E2, 9'h182, 9'h0C3, 9'h141, 9'h1FF, 9'h07F, 9'h000, 9'h1FF
  };

  utf8_stream_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .code_point_o   (code_point),
    .bad_trailing_o (bad_trailing),
    .overlong_o     (overlong),
    .not_unicode_o  (not_unicode),
    .end_kind_o     (end_kind),
    .end_of_string_o(end_of_string)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    decoded_t got;
    if (rst_ni && out_valid && out_ready) begin
      got.cp   = code_point;
      got.bad  = bad_trailing;
      got.ovl  = overlong;
      got.nu   = not_unicode;
      got.kind = end_kind_e'(end_kind);
      got.eos  = end_of_string;
      board.check_cp(got);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("utf8_stream_decoder regression: fail");
    $finish;
  end

  // Result side: shifting stall patterns, plus one long hold-off on request.
  initial begin : sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    mode_left = 0;
    mode      = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (tick % 7 != 3);
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    board.take_byte(b, lst);
  endtask

  function automatic void encode_cp(input logic [CpW-1:0] cp,
                                    input logic [WidthW-1:0] w,
                                    ref logic [7:0] q[$]);
    case (w)
      SEQ_W1: q.push_back({1'b0, cp[6:0]});
      SEQ_W2: begin
        q.push_back({3'b110, cp[10:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      SEQ_W3: begin
        q.push_back({4'b1110, cp[15:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        q.push_back({5'b11110, cp[20:18]});
        q.push_back({2'b10, cp[17:12]});
        q.push_back({2'b10, cp[11:6]});
        q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  task automatic append_char(ref logic [7:0] q[$]);
    int unsigned       roll;
    int unsigned       idx;
    logic [1:0]        top;
    logic [7:0]        tmp;
    logic [WidthW-1:0] w;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      encode_cp(CpW'($urandom_range(1, 'h7F)), SEQ_W1, q);
    end else if (roll < 55) begin
      encode_cp(CpW'($urandom_range('h80, 'h7FF)), SEQ_W2, q);
    end else if (roll < 70) begin
      encode_cp(CpW'($urandom_range('h800, 'hFFFF)), SEQ_W3, q);
    end else if (roll < 80) begin
      encode_cp(CpW'($urandom_range('h10000, 'h10FFFF)), SEQ_W4, q);
    end else if (roll < 86) begin
      // malformed values: overlong, surrogate, beyond the Unicode range
      case ($urandom_range(0, 3))
        0: begin
          w = 3'($urandom_range(2, 4));
          encode_cp(CpW'($urandom_range(1, (w == SEQ_W2) ? 'h7F
                                         : (w == SEQ_W3) ? 'h7FF : 'hFFFF)), w, q);
        end
        1:       encode_cp(CpW'($urandom_range('hD800, 'hDFFF)), SEQ_W3, q);
        2:       encode_cp(CpW'($urandom_range('h110000, 'h1FFFFF)), SEQ_W4, q);
        default: encode_cp(CpW'($urandom_range(0, 'h1FFFFF)), SEQ_W4, q);
      endcase
    end else if (roll < 89) begin
      encode_cp('0, 3'($urandom_range(1, 4)), q);
    end else if (roll < 94) begin
      q.push_back(8'($urandom_range(0, 255)));
    end else begin
      w = 3'($urandom_range(2, 4));
      encode_cp(CpW'($urandom_range('h80, 'h10FFFF)), w, q);
      idx = q.size() - $urandom_range(1, w - 1);
      top = 2'($urandom_range(0, 2));
      if (top == 2'b10) top = 2'b11;
      tmp      = q[idx];
      tmp[7:6] = top;
      q[idx]   = tmp;
    end
  endtask

  task automatic send_random_buffer();
    logic [7:0]  buf_q[$];
    int unsigned n_chars;
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) append_char(buf_q);
    // cut the buffer short now and then so it may end mid-sequence
    if (buf_q.size() > 1 && $urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, (buf_q.size() > 2) ? 2 : 1)) void'(buf_q.pop_back());
    foreach (buf_q[i]) push_byte(buf_q[i], i == buf_q.size() - 1);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_seq[i]) push_byte(directed_seq[i][7:0], directed_seq[i][8]);
    hold_off_req = 1'b1;
    while (board.consumed < BYTE_TARGET) send_random_buffer();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("utf8_stream_decoder regression: pass");
    end else begin
      $display("utf8_stream_decoder regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/u8sd_pkg.sv
sv/u8sd_front.sv
sv/u8sd_queue.sv
sv/u8sd_back.sv
sv/utf8_stream_decoder.sv
sim/testbench.sv
